// File: rtl/bmfns_pkg.sv
`timescale 1ns / 1ps

package bmfns_pkg;

	localparam int DEF_MAX_BITS = 4096;

	localparam int OPCODE_W = 3;
	localparam int POS_W    = 13;
	localparam int INDEX_W  = 12;
	localparam int COUNT_W  = 13;
	localparam int LENGTH_W = 13;

	localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_RESIZE = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_COUNT  = 3'd4;

	// Population count of one word as a short tree of field-wise sums.
	function automatic logic [5:0] pop32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		a = v - ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		d = c + (c >> 8);
		e = d + (d >> 16);
		pop32 = e[5:0];
	endfunction

	// Index of the lowest set bit: isolate it, then encode the one-hot word.
	function automatic logic [4:0] low_bit32(input logic [31:0] w);
		logic [31:0] iso;
		logic [4:0]  r;
		iso = w & (~w + 32'd1);
		r = '0;
		for (int j = 0; j < 32; j++) begin
			if (iso[j]) begin
				r = r | 5'(j);
			end
		end
		low_bit32 = r;
	endfunction

endpackage

// File: rtl/bitmap_store_find_next_set_core.sv
`timescale 1ns / 1ps
// A push of a zero, a rejected push, a resize that does not shrink, a find at or past the length or
// an unused opcode goes straight to S_DONE; a push of a one passes S_RMW_RD and S_RMW_WR first.
// Shrinking resize, clear, find and count step through each word they touch. One item is worked on
// at a time, read once per cycle from the single-port word memory; the next beat is taken the cycle
// after the result is loaded. Reset starts a clearing pass over all NWORDS words that takes no beat.
module bitmap_store_find_next_set_core #(
	parameter int MAX_BITS = bmfns_pkg::DEF_MAX_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bmfns_pkg::OPCODE_W-1:0]   opcode,
	input  logic                             bit_value,
	input  logic [bmfns_pkg::POS_W-1:0]      position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bmfns_pkg::INDEX_W-1:0]    result_index,
	output logic                             found,
	output logic [bmfns_pkg::COUNT_W-1:0]    set_count,
	output logic [bmfns_pkg::LENGTH_W-1:0]   current_length,
	output logic                             status
);

	localparam int NWORDS = (MAX_BITS + 31) / 32;
	localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int CNT_W  = $clog2(NWORDS + 1);
	localparam int LEN_W  = $clog2(MAX_BITS + 1);
	localparam int IDX_W  = $clog2(MAX_BITS);
	localparam int CW     = (LEN_W > bmfns_pkg::POS_W) ? LEN_W : bmfns_pkg::POS_W;

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_RMW_RD = 3'd2;
	localparam logic [2:0] S_RMW_WR = 3'd3;
	localparam logic [2:0] S_ZERO   = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	function automatic logic [CNT_W-1:0] used_words(input logic [LEN_W-1:0] n);
		logic [LEN_W:0] t;
		t = {1'b0, n} + (LEN_W + 1)'(31);
		used_words = CNT_W'(t >> 5);
	endfunction

	logic [31:0] mem [NWORDS];

	logic [2:0]                      state_q;
	logic [bmfns_pkg::OPCODE_W-1:0]  op_q;
	logic [LEN_W-1:0]                len_q;
	logic [CNT_W-1:0]                addr_q;
	logic [CNT_W-1:0]                end_q;
	logic [WA-1:0]                   first_q;
	logic [4:0]                      bsel_q;
	logic [IDX_W-1:0]                idx_q;
	logic                            found_q;
	logic [LEN_W-1:0]                cnt_q;
	logic                            status_q;
	logic                            rv_s1;
	logic [WA-1:0]                   raddr_s1;
	logic [31:0]                     rdata_s1;

	logic                            out_valid_q;
	logic [bmfns_pkg::INDEX_W-1:0]   result_index_q;
	logic                            found_out_q;
	logic [bmfns_pkg::COUNT_W-1:0]   set_count_q;
	logic [bmfns_pkg::LENGTH_W-1:0]  current_length_q;
	logic                            status_out_q;

	logic [CW-1:0]   pos_x;
	logic [CW-1:0]   len_x;
	logic            accept;
	logic            issue;
	logic            mem_we;
	logic            mem_re;
	logic [WA-1:0]   mem_addr;
	logic [31:0]     mem_wdata;
	logic [31:0]     low_mask;
	logic [31:0]     scan_word;
	logic            hit;
	logic            out_load;

	assign pos_x    = CW'(position);
	assign len_x    = CW'(len_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == S_SCAN) && (addr_q < end_q) && !found_q;
	assign low_mask = (32'd1 << bsel_q) - 32'd1;
	assign mem_addr = addr_q[WA-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_ZERO: begin
				mem_we = (addr_q < end_q);
			end
			S_RMW_WR: begin
				mem_we = 1'b1;
				if (op_q == bmfns_pkg::OP_PUSH) begin
					mem_wdata = rdata_s1 | (32'd1 << bsel_q);
				end else begin
					mem_wdata = rdata_s1 & low_mask;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re = (state_q == S_RMW_RD) || issue;

	// Only the word that holds the start position loses its low bits.
	assign scan_word = (raddr_s1 == first_q) ? (rdata_s1 & ~low_mask) : rdata_s1;
	assign hit = rv_s1 && (op_q == bmfns_pkg::OP_FIND) && (scan_word != 32'd0) && !found_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_addr];
		end
		raddr_s1 <= mem_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			op_q     <= bmfns_pkg::OP_PUSH;
			len_q    <= '0;
			addr_q   <= '0;
			end_q    <= '0;
			first_q  <= '0;
			bsel_q   <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			status_q <= 1'b0;
			rv_s1    <= 1'b0;
		end else begin
			rv_s1 <= issue;
			case (state_q)
				S_INIT: begin
					if (addr_q == CNT_W'(NWORDS - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode;
						idx_q    <= '0;
						found_q  <= 1'b0;
						cnt_q    <= '0;
						status_q <= 1'b0;
						first_q  <= '0;
						bsel_q   <= '0;
						end_q    <= used_words(len_q);
						state_q  <= S_DONE;
						case (opcode)
							bmfns_pkg::OP_PUSH: begin
								if (len_q >= LEN_W'(MAX_BITS)) begin
									status_q <= 1'b1;
								end else begin
									idx_q  <= IDX_W'(len_q);
									len_q  <= len_q + 1'b1;
									bsel_q <= len_q[4:0];
									addr_q <= CNT_W'(len_q >> 5);
									if (bit_value) begin
										state_q <= S_RMW_RD;
									end
								end
							end
							bmfns_pkg::OP_RESIZE: begin
								if (pos_x > CW'(MAX_BITS)) begin
									status_q <= 1'b1;
								end else begin
									len_q <= LEN_W'(pos_x);
									if (pos_x < len_x) begin
										bsel_q <= position[4:0];
										if (position[4:0] != 5'd0) begin
											addr_q  <= CNT_W'(pos_x >> 5);
											state_q <= S_RMW_RD;
										end else begin
											addr_q  <= used_words(LEN_W'(pos_x));
											state_q <= S_ZERO;
										end
									end
								end
							end
							bmfns_pkg::OP_CLEAR: begin
								addr_q  <= '0;
								state_q <= S_ZERO;
							end
							bmfns_pkg::OP_FIND: begin
								if (pos_x < len_x) begin
									addr_q  <= CNT_W'(pos_x >> 5);
									first_q <= WA'(pos_x >> 5);
									bsel_q  <= position[4:0];
									state_q <= S_SCAN;
								end
							end
							bmfns_pkg::OP_COUNT: begin
								addr_q  <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					if (op_q == bmfns_pkg::OP_PUSH) begin
						state_q <= S_DONE;
					end else begin
						// The partial word is done; the whole words above it follow.
						addr_q  <= addr_q + 1'b1;
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					if (addr_q < end_q) begin
						addr_q <= addr_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (hit) begin
						found_q <= 1'b1;
						idx_q   <= IDX_W'({raddr_s1, bmfns_pkg::low_bit32(scan_word)});
					end
					if (rv_s1 && (op_q == bmfns_pkg::OP_COUNT)) begin
						cnt_q <= cnt_q + LEN_W'(bmfns_pkg::pop32(rdata_s1));
					end
					if (!issue && !rv_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_index_q   <= bmfns_pkg::INDEX_W'(idx_q);
			found_out_q      <= found_q;
			set_count_q      <= bmfns_pkg::COUNT_W'(cnt_q);
			current_length_q <= bmfns_pkg::LENGTH_W'(len_q);
			status_out_q     <= status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_index   = result_index_q;
	assign found          = found_out_q;
	assign set_count      = set_count_q;
	assign current_length = current_length_q;
	assign status         = status_out_q;

endmodule
